/* rtl/tfd_pkg.sv */
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants of the tilt fall detector
// Holds the controller state type, command and status structs, and the
// arctangent table used by the shared CORDIC datapath.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int unsigned CordicIter = 16;
  localparam int unsigned IterW = $clog2(CordicIter + 1);
  localparam logic signed [31:0] AngleLimit = 32'sd4608000;
  localparam logic signed [31:0] AccLimit = 32'sd2304000;
  localparam logic [14:0] ThreshReset = 15'd5000;
  localparam logic [10:0] WeightReset = 11'd978;
  localparam logic [1:0] RegThresh = 2'd0;
  localparam logic [1:0] RegWeight = 2'd1;

  // Division of the gyro increment by five: a bias that is a multiple of five
  // and makes rate*dt positive, its quotient, the reciprocal of five for a
  // 19-bit dividend (shift 22) and 2^17 div 5.
  localparam logic signed [34:0] DeltaBias = 35'sd10737418240;
  localparam logic signed [36:0] BiasQuot = 37'sd2147483648;
  localparam logic [19:0] RecipFive = 20'd838861;
  localparam logic [14:0] HighFive = 15'd26214;

  typedef enum logic [3:0] {
    StIdle,
    StSqrt,
    StCordic,
    StPred,
    StMul1,
    StMul2,
    StMix,
    StNext,
    StFinish,
    StOut
  } state_e;

  typedef struct packed {
    logic load;       // capture an input sample
    logic sqrt_init;  // start a square root for the current axis
    logic sqrt_step;
    logic cordic_init;
    logic cordic_step;
    logic pred;
    logic mul1;
    logic mul2;
    logic mix;
    logic axis;       // 0 = roll, 1 = pitch
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic cordic_done;
  } status_t;

  function automatic logic signed [31:0] atan_q8(input logic [4:0] i);
    logic signed [31:0] r;
    begin
      case (i)
        5'd0: r = 32'sd1152000;
        5'd1: r = 32'sd680065;
        5'd2: r = 32'sd359328;
        5'd3: r = 32'sd182400;
        5'd4: r = 32'sd91554;
        5'd5: r = 32'sd45822;
        5'd6: r = 32'sd22916;
        5'd7: r = 32'sd11459;
        5'd8: r = 32'sd5730;
        5'd9: r = 32'sd2865;
        5'd10: r = 32'sd1432;
        5'd11: r = 32'sd716;
        5'd12: r = 32'sd358;
        5'd13: r = 32'sd179;
        5'd14: r = 32'sd90;
        5'd15: r = 32'sd45;
        5'd16: r = 32'sd22;
        5'd17: r = 32'sd11;
        5'd18: r = 32'sd6;
        5'd19: r = 32'sd3;
        5'd20: r = 32'sd1;
        5'd21: r = 32'sd1;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/tfd_if.sv */
// ----------------------------------------------------------------------------
// tfd_if: valid/ready channel interfaces of the tilt fall detector
// One interface for input samples and one for filtered results.
// ----------------------------------------------------------------------------
interface tfd_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [15:0] elapsed_ms;
  logic button_pressed;
  modport source (output valid, rate_x, rate_y, accel_x, accel_y, accel_z,
                  elapsed_ms, button_pressed, input ready);
  modport sink (input valid, rate_x, rate_y, accel_x, accel_y, accel_z,
                elapsed_ms, button_pressed, output ready);
endinterface

interface tfd_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic tilt_exceeded;
  logic alarm_active;
  modport source (output valid, roll_angle, pitch_angle, tilt_exceeded,
                  alarm_active, input ready);
  modport sink (input valid, roll_angle, pitch_angle, tilt_exceeded,
                alarm_active, output ready);
endinterface

/* rtl/tfd_ctrl.sv */
// ----------------------------------------------------------------------------
// tfd_ctrl: sequencer of the tilt fall detector
// Steps the datapath through square root, CORDIC and filter for each axis.
// ----------------------------------------------------------------------------
module tfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tfd_pkg::status_t status_i,
  output tfd_pkg::cmd_t    cmd_o
);

  tfd_pkg::state_e state_q, state_d;
  logic axis_q, axis_d;
  logic ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfd_pkg::StIdle;
      axis_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q <= axis_d;
      ovalid_q <= ovalid_d;
    end
  end

  // The result register frees up as soon as it is taken, so a new sample
  // may be in work while the last result waits.
  always_comb begin
    state_d = state_q;
    axis_d = axis_q;
    unique case (state_q)
      tfd_pkg::StIdle: if (in_valid_i) begin
        state_d = tfd_pkg::StSqrt;
        axis_d = 1'b0;
      end
      tfd_pkg::StSqrt: if (status_i.sqrt_done) state_d = tfd_pkg::StCordic;
      tfd_pkg::StCordic: if (status_i.cordic_done) state_d = tfd_pkg::StPred;
      tfd_pkg::StPred: state_d = tfd_pkg::StMul1;
      tfd_pkg::StMul1: state_d = tfd_pkg::StMul2;
      tfd_pkg::StMul2: state_d = tfd_pkg::StMix;
      tfd_pkg::StMix: state_d = tfd_pkg::StNext;
      tfd_pkg::StNext: begin
        if (axis_q) state_d = tfd_pkg::StFinish;
        else begin
          state_d = tfd_pkg::StSqrt;
          axis_d = 1'b1;
        end
      end
      tfd_pkg::StFinish: state_d = tfd_pkg::StOut;
      tfd_pkg::StOut: if (!ovalid_q || out_ready_i) state_d = tfd_pkg::StIdle;
      default: state_d = tfd_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.axis = axis_q;
    in_ready_o = (state_q == tfd_pkg::StIdle);
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      tfd_pkg::StIdle: begin
        cmd_o.load = in_valid_i;
      end
      tfd_pkg::StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.cordic_init = status_i.sqrt_done;
      end
      tfd_pkg::StCordic: cmd_o.cordic_step = 1'b1;
      tfd_pkg::StPred: cmd_o.pred = 1'b1;
      tfd_pkg::StMul1: cmd_o.mul1 = 1'b1;
      tfd_pkg::StMul2: cmd_o.mul2 = 1'b1;
      tfd_pkg::StMix: cmd_o.mix = 1'b1;
      tfd_pkg::StNext: begin
        cmd_o.sqrt_init = !axis_q;
      end
      tfd_pkg::StFinish: cmd_o.finish = 1'b1;
      tfd_pkg::StOut: if (!ovalid_q || out_ready_i) begin
        cmd_o.out_load = 1'b1;
        ovalid_d = 1'b1;
      end
      default: ;
    endcase
    if (state_q == tfd_pkg::StIdle && in_valid_i) cmd_o.sqrt_init = 1'b1;
  end

  assign out_valid_o = ovalid_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != tfd_pkg::StIdle |-> !in_ready_o)
    else $error("ready while busy");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == tfd_pkg::StSqrt)
    else $error("sample load without start");

endmodule

/* rtl/tfd_dp.sv */
// ----------------------------------------------------------------------------
// tfd_dp: datapath of the tilt fall detector
// Shared square root and CORDIC units, filter arithmetic, alarm latch.
// ----------------------------------------------------------------------------
module tfd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfd_pkg::cmd_t       cmd_i,
  output tfd_pkg::status_t    status_o,
  input  logic signed [15:0]  rate_x_i,
  input  logic signed [15:0]  rate_y_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic [15:0]         elapsed_ms_i,
  input  logic                button_pressed_i,
  input  logic [14:0]         thresh_i,
  input  logic [10:0]         weight_i,
  output logic signed [15:0]  roll_o,
  output logic signed [15:0]  pitch_o,
  output logic                tilt_o,
  output logic                alarm_o
);

  // Captured sample.
  logic signed [15:0] rx_q, ry_q, ax_q, ay_q, az_q;
  logic [15:0] dt_q;
  logic btn_q;

  // Square root: 33-bit radicand, 17 result bits, one bit pair per cycle.
  // The partial root is held scaled up and shifted down during the run, so it is
  // as wide as the radicand.
  logic [32:0] rad_q, rad_d;
  logic [32:0] root_q, root_d;
  logic [32:0] bit_q, bit_d;
  logic [33:0] trial;

  // CORDIC vectoring.
  logic signed [34:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic [tfd_pkg::IterW-1:0] it_q;
  logic czero_q;
  logic signed [31:0] acc_q;

  // Filter.
  logic signed [31:0] roll_est_q, pitch_est_q;
  logic signed [31:0] pred_q;
  logic signed [36:0] delta_q, delta_c;
  logic signed [34:0] rdt;
  logic [33:0] u_q;
  logic [16:0] uh_q, tq_q;
  logic [18:0] t_q, t_c, rem5;
  logic [38:0] tq_prod;
  logic [32:0] q5;
  logic [2:0] frac;
  logic signed [41:0] pred_sum;
  logic signed [47:0] p1_q, p2_q;
  logic signed [31:0] mixc;
  logic signed [49:0] mixs;
  logic signed [31:0] est_cur;
  logic [10:0] w_c;
  logic alarm_q;
  logic alarm_out_q;
  logic signed [15:0] roll_q, pitch_q;
  logic tilt_q;
  logic signed [16:0] ox, oy;

  logic signed [16:0] nax;
  logic signed [31:0] sq_a, sq_z;
  assign nax = -{ax_q[15], ax_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rx_q <= rate_x_i; ry_q <= rate_y_i;
      ax_q <= accel_x_i; ay_q <= accel_y_i; az_q <= accel_z_i;
      dt_q <= elapsed_ms_i; btn_q <= button_pressed_i;
    end
  end

  // Radicand for the square root of the current axis, computed at init.
  logic signed [15:0] sq_src_a, sq_src_z;
  always_comb begin
    // The load cycle sees the inputs directly; later the captured sample.
    if (cmd_i.load) begin
      sq_src_a = accel_x_i; sq_src_z = accel_z_i;
    end else begin
      sq_src_a = cmd_i.axis ? ay_q : ax_q; sq_src_z = az_q;
    end
    // At the end of roll (StNext) axis is 0 but pitch needs accel_y.
    if (!cmd_i.load) sq_src_a = ay_q;
    sq_a = sq_src_a * sq_src_a;
    sq_z = sq_src_z * sq_src_z;
  end

  assign trial = {1'b0, rad_q} - ({1'b0, root_q} + {1'b0, bit_q});
  always_comb begin
    rad_d = rad_q; root_d = root_q; bit_d = bit_q;
    if (cmd_i.sqrt_init) begin
      rad_d = {1'b0, 32'(unsigned'(sq_a))} + {1'b0, 32'(unsigned'(sq_z))};
      root_d = '0;
      bit_d = 33'h1_0000_0000;
    end else if (cmd_i.sqrt_step && bit_q != '0) begin
      if (!trial[33]) begin
        rad_d = trial[32:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
  end
  assign status_o.sqrt_done = (bit_q == '0);

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d; root_q <= root_d; bit_q <= bit_d;
  end

  // CORDIC: y operand is accel_y (roll) or -accel_x (pitch), x is the root.
  logic signed [16:0] cy_src;
  logic signed [34:0] dx, dy;
  assign cy_src = cmd_i.axis ? nax : {ay_q[15], ay_q};
  assign dx = cx_q >>> it_q;
  assign dy = cy_q >>> it_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_init) begin
      cx_q <= 35'(signed'({1'b0, root_q[16:0]})) <<< 12;
      cy_q <= 35'(cy_src) <<< 12;
      cz_q <= '0;
      it_q <= '0;
      czero_q <= (root_q == '0) && (cy_src == '0);
    end else if (cmd_i.cordic_step && !status_o.cordic_done) begin
      if (!cy_q[34]) begin
        cx_q <= cx_q + dy; cy_q <= cy_q - dx;
        cz_q <= cz_q + tfd_pkg::atan_q8(5'(it_q));
      end else begin
        cx_q <= cx_q - dy; cy_q <= cy_q + dx;
        cz_q <= cz_q - tfd_pkg::atan_q8(5'(it_q));
      end
      it_q <= it_q + 1'b1;
    end
  end
  assign status_o.cordic_done = (it_q == tfd_pkg::IterW'(tfd_pkg::CordicIter));

  // Gyro increment floor((16*r + 5) / 10) with r = rate*dt. Since
  // 16*r + 5 = 80*(r div 5) + 16*(r mod 5) + 5, the increment is
  // 8*(r div 5) plus a small value picked by the remainder. r is made positive
  // by a bias that is a multiple of five, split at bit 17 (2^17 = 5*26214 + 2)
  // and the low part plus twice the high part is divided by a reciprocal
  // multiplication. The two register stages settle while CORDIC iterates.
  assign rdt = 35'((cmd_i.axis ? ry_q : rx_q) * $signed({1'b0, dt_q}));
  assign t_c = {1'b0, u_q[33:17], 1'b0} + {2'b0, u_q[16:0]};
  assign tq_prod = 39'(t_c) * 39'(tfd_pkg::RecipFive);
  assign q5 = 33'(uh_q) * 33'(tfd_pkg::HighFive) + 33'(tq_q);
  assign rem5 = t_q - ({tq_q, 2'b0} + {2'b0, tq_q});
  always_comb begin
    case (rem5[2:0])
      3'd1: frac = 3'd2;
      3'd2: frac = 3'd3;
      3'd3: frac = 3'd5;
      3'd4: frac = 3'd6;
      default: frac = 3'd0;
    endcase
  end
  assign delta_c = (($signed({4'b0, q5}) - tfd_pkg::BiasQuot) <<< 3)
                   + $signed({34'b0, frac});

  // Filter steps.
  assign est_cur = cmd_i.axis ? pitch_est_q : roll_est_q;
  assign w_c = (weight_i > 11'd1024) ? 11'd1024 : weight_i;
  assign pred_sum = 42'(est_cur) + 42'(delta_q);
  assign mixs = 50'(p1_q) + 50'(p2_q) + 50'sd512;
  always_comb begin
    logic signed [39:0] sh;
    sh = 40'(mixs >>> 10);
    if (sh > 40'(tfd_pkg::AngleLimit)) mixc = tfd_pkg::AngleLimit;
    else if (sh < -40'(tfd_pkg::AngleLimit)) mixc = -tfd_pkg::AngleLimit;
    else mixc = 32'(sh);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_init) u_q <= 34'(rdt + tfd_pkg::DeltaBias);
    if (cmd_i.cordic_step) begin
      uh_q <= u_q[33:17];
      t_q <= t_c;
      tq_q <= tq_prod[38:22];
      delta_q <= delta_c;
    end
    if (cmd_i.cordic_step && status_o.cordic_done) begin
      if (czero_q) acc_q <= '0;
      else if (cz_q > tfd_pkg::AccLimit) acc_q <= tfd_pkg::AccLimit;
      else if (cz_q < -tfd_pkg::AccLimit) acc_q <= -tfd_pkg::AccLimit;
      else acc_q <= cz_q;
    end
    if (cmd_i.pred) begin
      if (pred_sum > 42'(tfd_pkg::AngleLimit)) pred_q <= tfd_pkg::AngleLimit;
      else if (pred_sum < -42'(tfd_pkg::AngleLimit)) pred_q <= -tfd_pkg::AngleLimit;
      else pred_q <= 32'(pred_sum);
    end
    if (cmd_i.mul1) p1_q <= 48'(pred_q * $signed({1'b0, w_c}));
    if (cmd_i.mul2) p2_q <= 48'(acc_q * $signed({1'b0, 11'(12'd1024 - {1'b0, w_c})}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_est_q <= '0; pitch_est_q <= '0; alarm_q <= 1'b0;
    end else begin
      if (cmd_i.mix) begin
        if (cmd_i.axis) pitch_est_q <= mixc;
        else roll_est_q <= mixc;
      end
      if (cmd_i.finish) begin
        if (btn_q) alarm_q <= 1'b0;
        else if (($signed(ox) > $signed({2'b0, thresh_i}))
                 || ($signed(oy) > $signed({2'b0, thresh_i}))) alarm_q <= 1'b1;
      end
    end
  end

  logic signed [32:0] rs, ps;
  assign rs = (33'(roll_est_q) + 33'sd128) >>> 8;
  assign ps = (33'(pitch_est_q) + 33'sd128) >>> 8;
  assign ox = 17'(rs);
  assign oy = 17'(ps);

  // The alarm is copied with the angles so a waiting result keeps its value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      roll_q <= ox[15:0];
      pitch_q <= oy[15:0];
      tilt_q <= ($signed(ox) > $signed({2'b0, thresh_i}))
                || ($signed(oy) > $signed({2'b0, thresh_i}));
      alarm_out_q <= alarm_q;
    end
  end

  assign roll_o = roll_q;
  assign pitch_o = pitch_q;
  assign tilt_o = tilt_q;
  assign alarm_o = alarm_out_q;

  a_est_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    roll_est_q <= tfd_pkg::AngleLimit && roll_est_q >= -tfd_pkg::AngleLimit)
    else $error("roll estimate out of range");
  a_btn_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && btn_q |=> !alarm_q)
    else $error("button did not clear alarm");
  a_cordic_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.cordic_done && !cmd_i.cordic_init |=> $stable(it_q))
    else $error("CORDIC ran past its iteration count");

endmodule

/* rtl/tilt_fall_detector_top.sv */
// ----------------------------------------------------------------------------
// tilt_fall_detector_top: complementary-filter tilt estimator with fall alarm
// APB register port, valid/ready sample and result channels.
// ----------------------------------------------------------------------------
// Once a sample is accepted, each of the two axes goes through a bit-serial
// square root (17 bit-pair steps and a done check), CORDIC vectoring (16
// iterations, one per cycle, and a done check) and the filter arithmetic and
// axis change (StPred, StMul1, StMul2, StMix, StNext); then the alarm latch is
// updated and the output register is loaded with its valid flag set. The gyro
// increment is divided down while CORDIC iterates and adds no state of its
// own. A single square root unit and a single CORDIC unit are shared by both
// axes; one sample is worked at a time, and the next one can be accepted in
// the cycle after the result is loaded. The result sits in an output register,
// so the next sample is accepted while it waits to be taken; only when that
// sample is done and the old result is still waiting does the block stall.
// Registers: fall_threshold at byte address 0 and gyro_weight at 4; write them
// only while the block is idle. A gyro weight above 1024 acts as 1024.
module tilt_fall_detector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tfd_in_if.sink      in_if,
  tfd_out_if.source   out_if
);

  logic [14:0] thresh_q;
  logic [10:0] weight_q;
  tfd_pkg::cmd_t cmd;
  tfd_pkg::status_t status;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= tfd_pkg::ThreshReset;
      weight_q <= tfd_pkg::WeightReset;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == tfd_pkg::RegThresh[0]) thresh_q <= pwdata[14:0];
      else if (paddr[2] == tfd_pkg::RegWeight[0]) weight_q <= pwdata[10:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tfd_pkg::RegWeight[0]) prdata = {21'b0, weight_q};
    else prdata = {17'b0, thresh_q};
  end

  tfd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .status_i(status), .cmd_o(cmd)
  );

  tfd_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .rate_x_i(in_if.rate_x), .rate_y_i(in_if.rate_y),
    .accel_x_i(in_if.accel_x), .accel_y_i(in_if.accel_y),
    .accel_z_i(in_if.accel_z), .elapsed_ms_i(in_if.elapsed_ms),
    .button_pressed_i(in_if.button_pressed),
    .thresh_i(thresh_q), .weight_i(weight_q),
    .roll_o(out_if.roll_angle), .pitch_o(out_if.pitch_angle),
    .tilt_o(out_if.tilt_exceeded), .alarm_o(out_if.alarm_active)
  );

endmodule
